### hw/rtl/dogc_pkg.sv
// Shared package for the degree-ordered greedy colouring block.
// Holds the item structs, the controller/datapath command and status structs,
// and the configuration constants. Depends on nothing.
package dogc_pkg;

  localparam int ID_W             = 4;
  localparam int ID_RANGE         = 1 << ID_W;
  localparam int VC_W             = 5;
  localparam int DEF_MAX_VERTICES = 16;
  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0] end_a;
    logic [ID_W-1:0] end_b;
    logic            final_edge;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] vertex_id;
    logic [ID_W-1:0] color_id;
    logic            last_vertex;
  } out_item_t;

  typedef struct packed {
    logic edge_wr;
    logic run_init;
    logic deg_step;
    logic sel_step;
    logic used_calc;
    logic color_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic deg_last;
    logic vertex_picked;
    logic run_last;
  } dp_status_t;

endpackage

### hw/rtl/dogc_dp.sv
// Datapath of the degree-ordered greedy colouring block: adjacency matrix,
// degree and colour registers, vertex selection and colour pick.
// Depends on dogc_pkg; driven by commands from dogc_ctrl.
module dogc_dp #(
  parameter int MAX_VERTICES = dogc_pkg::DEF_MAX_VERTICES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dogc_pkg::VC_W-1:0]  vertex_count,
  input  dogc_pkg::in_item_t         in_item,
  input  dogc_pkg::dp_cmd_t          cmd,
  output dogc_pkg::dp_status_t       st,
  output dogc_pkg::out_item_t        out_item
);

  // Edge ends are only ID_W bits wide, so only the low vertices can have edges.
  localparam int AW  = (MAX_VERTICES < dogc_pkg::ID_RANGE) ? MAX_VERTICES : dogc_pkg::ID_RANGE;
  localparam int AIW = $clog2(AW);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int DW  = $clog2(AW);
  localparam int CW  = $clog2(AW);
  localparam int IDW = dogc_pkg::ID_W;

  logic [NW-1:0]  n_act;
  logic [AW-1:0]  keep;
  logic [AW-1:0]  rows_r [AW];
  logic [DW-1:0]  deg_r [AW];
  logic [CW-1:0]  color_r [AW];
  logic [AW-1:0]  colored_r;
  logic [AW-1:0]  done_r;
  logic [AIW-1:0] idx_r;
  logic [DW-1:0]  level_r;
  logic [NW-1:0]  tail_r;
  logic [NW-1:0]  emit_r;
  logic [VW-1:0]  v_r;
  logic [AW-1:0]  used_r;
  logic [AW-1:0]  used_nxt;
  dogc_pkg::out_item_t out_r;

  logic           edge_ok;
  logic [AIW-1:0] ai;
  logic [AIW-1:0] bi;
  logic           v_in;
  logic [AIW-1:0] v_ai;
  logic [AW-1:0]  row_rd;
  logic [AW-1:0]  nbr;
  logic [DW-1:0]  deg_cnt;
  logic [AW-1:0]  match;
  logic           m_any;
  logic [AIW-1:0] m_idx;
  logic [CW-1:0]  c_pick;

  // Effective vertex count, clamped to 1 .. MAX_VERTICES.
  always_comb begin
    if (vertex_count == '0) begin
      n_act = NW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_act = NW'(MAX_VERTICES);
    end else begin
      n_act = NW'(vertex_count);
    end
  end

  for (genvar g = 0; g < AW; g++) begin : g_keep
    assign keep[g]  = (32'(g) < 32'(n_act));
    assign match[g] = keep[g] && (deg_r[g] == level_r) && !done_r[g];
  end

  assign ai      = AIW'(in_item.end_a);
  assign bi      = AIW'(in_item.end_b);
  assign edge_ok = cmd.edge_wr && (in_item.end_a != in_item.end_b) &&
                   (32'(in_item.end_a) < 32'(n_act)) && (32'(in_item.end_b) < 32'(n_act));

  assign v_in = (32'(v_r) < AW);
  assign v_ai = AIW'(v_r);

  // One row read port, shared by the degree count and the neighbour scan.
  always_comb begin
    row_rd = '0;
    if (cmd.deg_step) begin
      row_rd = rows_r[idx_r];
    end else if (v_in) begin
      row_rd = rows_r[v_ai];
    end
  end
  assign nbr = row_rd & keep;

  always_comb begin
    int cnt;
    cnt = 0;
    for (int j = 0; j < AW; j++) begin
      cnt = cnt + int'(nbr[j]);
    end
    deg_cnt = DW'(cnt);
  end

  // Colours already held by coloured neighbours.
  always_comb begin
    used_nxt = '0;
    for (int j = 0; j < AW; j++) begin
      if (nbr[j] && colored_r[j]) begin
        used_nxt[color_r[j]] = 1'b1;
      end
    end
  end

  always_comb begin
    c_pick = '0;
    for (int j = AW - 1; j >= 0; j--) begin
      if (!used_r[j]) begin
        c_pick = CW'(j);
      end
    end
  end

  always_comb begin
    m_idx = '0;
    for (int j = AW - 1; j >= 0; j--) begin
      if (match[j]) begin
        m_idx = AIW'(j);
      end
    end
  end
  assign m_any = |match;

  assign st.deg_last      = (idx_r == AIW'(AW - 1));
  assign st.vertex_picked = m_any || (level_r == '0);
  assign st.run_last      = (emit_r == n_act - NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AW; i++) begin
        rows_r[i] <= '0;
      end
      colored_r <= '0;
      done_r    <= '0;
      idx_r     <= '0;
      level_r   <= '0;
      tail_r    <= '0;
      emit_r    <= '0;
    end else begin
      if (edge_ok) begin
        rows_r[ai][bi] <= 1'b1;
        rows_r[bi][ai] <= 1'b1;
      end
      if (cmd.run_init) begin
        idx_r   <= '0;
        level_r <= DW'(AW - 1);
        tail_r  <= NW'(AW);
        emit_r  <= '0;
        done_r  <= '0;
      end
      if (cmd.deg_step) begin
        idx_r <= idx_r + AIW'(1);
      end
      if (cmd.sel_step) begin
        if (m_any) begin
          done_r[m_idx] <= 1'b1;
        end else if (level_r != '0) begin
          level_r <= level_r - DW'(1);
        end else begin
          tail_r <= tail_r + NW'(1);
        end
      end
      if (cmd.color_wr) begin
        emit_r <= emit_r + NW'(1);
        // The run ends here: the graph is wiped for the next one.
        if (st.run_last) begin
          for (int i = 0; i < AW; i++) begin
            rows_r[i] <= '0;
          end
          colored_r <= '0;
        end else if (v_in) begin
          colored_r[v_ai] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deg_step) begin
      deg_r[idx_r] <= deg_cnt;
    end
    if (cmd.sel_step) begin
      v_r <= m_any ? VW'(m_idx) : VW'(tail_r);
    end
    if (cmd.used_calc) begin
      used_r <= used_nxt;
    end
    if (cmd.color_wr) begin
      if (v_in) begin
        color_r[v_ai] <= c_pick;
      end
      out_r.vertex_id   <= IDW'(v_r);
      out_r.color_id    <= IDW'(c_pick);
      out_r.last_vertex <= st.run_last;
    end
  end

  assign out_item = out_r;

endmodule

### hw/rtl/dogc_ctrl.sv
// Controller of the degree-ordered greedy colouring block: sequences edge
// loading, degree count, vertex selection and colouring, and owns out_valid.
// Depends on dogc_pkg; drives dogc_dp through the command struct.
module dogc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_final,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dogc_pkg::dp_cmd_t     cmd,
  input  dogc_pkg::dp_status_t  st
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_LOAD = 3'd0;
  localparam logic [ST_W-1:0] ST_DEG  = 3'd1;
  localparam logic [ST_W-1:0] ST_SEL  = 3'd2;
  localparam logic [ST_W-1:0] ST_USED = 3'd3;
  localparam logic [ST_W-1:0] ST_PICK = 3'd4;

  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.edge_wr = 1'b1;
          if (in_final) begin
            cmd.run_init = 1'b1;
            state_nxt    = ST_DEG;
          end
        end
      end
      ST_DEG: begin
        cmd.deg_step = 1'b1;
        if (st.deg_last) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd.sel_step = 1'b1;
        if (st.vertex_picked) begin
          state_nxt = ST_USED;
        end
      end
      ST_USED: begin
        cmd.used_calc = 1'b1;
        state_nxt     = ST_PICK;
      end
      ST_PICK: begin
        if (slot_free) begin
          cmd.color_wr  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = st.run_last ? ST_LOAD : ST_SEL;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/degree_ordered_greedy_coloring.sv
// Top level of the degree-ordered greedy colouring block, with its APB register.
// Depends on dogc_pkg, dogc_ctrl and dogc_dp.
//
// The block takes an undirected graph one edge item per clock cycle while
// loading and marks it in a symmetric adjacency matrix; self-loops and edges
// touching a vertex at or above the vertex count are dropped. When the item
// flagged final_edge has been taken, input is held off while the vertices
// are ranked by falling degree (lower index first on ties) and each is given
// the smallest colour that none of its already coloured neighbours holds. One
// result item per vertex in use follows, in that rank, the final one with
// last_vertex set; the graph is then cleared and edges are taken again, even
// while that final result still waits in the output register. After the final
// edge the degree count steps through every matrix row (the matrix has
// min(MAX_VERTICES, 16) rows, as edge ends are four bits wide); then each
// vertex passes through select, neighbour scan and colour pick, with one
// more select step for every degree level passed with no vertex left on it,
// each level being passed at most once over the whole run. Vertices at or
// above sixteen have no edges and take colour zero. The vertex_count register
// sits at byte address 0; a count of zero acts as one and a count above
// MAX_VERTICES acts as MAX_VERTICES. It is to be written only while no run is
// in progress.
module degree_ordered_greedy_coloring #(
  parameter int MAX_VERTICES = dogc_pkg::DEF_MAX_VERTICES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dogc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dogc_pkg::out_item_t              out_item,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dogc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [dogc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dogc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  logic [dogc_pkg::VC_W-1:0]      vc_r;
  logic [dogc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  dogc_pkg::dp_cmd_t              cmd;
  dogc_pkg::dp_status_t           st;

  // The port never stalls; a write lands in the access phase.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[dogc_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= dogc_pkg::VC_RESET;
    end else if (cfg_wr && (reg_idx == dogc_pkg::REG_VERTEX_COUNT)) begin
      vc_r <= cfg_pwdata[dogc_pkg::VC_W-1:0];
    end
  end

  // Reads of addresses beyond the register list return zero.
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      dogc_pkg::REG_VERTEX_COUNT: cfg_prdata = dogc_pkg::CFG_DATA_W'(vc_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  dogc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_item.final_edge),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  dogc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_count (vc_r),
    .in_item      (in_item),
    .cmd          (cmd),
    .st           (st),
    .out_item     (out_item)
  );

endmodule

### tb/degree_ordered_greedy_coloring_test.sv
// Self-checking testbench for the degree-ordered greedy colouring block.
// Drives edge items and the vertex_count register, and checks every colour result.
// Depends on dogc_pkg and degree_ordered_greedy_coloring.
module degree_ordered_greedy_coloring_test;

  localparam int NV           = dogc_pkg::DEF_MAX_VERTICES;
  localparam int RANDOM_ITEMS = 180;
  // Cycles left after the last result before the register is touched, so that
  // any edge item still on its way into the matrix has landed.
  localparam int SETTLE       = 2 * NV;
  // Roughly one full unstalled colouring pass.
  localparam int RUN_CYCLES   = 3 * NV + 2 * NV;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;

  // The only result whose value is obvious without working it through: a
  // single vertex in use always comes out alone, colour zero, flagged last.
  localparam dogc_pkg::out_item_t ONE_VERTEX =
    '{vertex_id: '0, color_id: '0, last_vertex: 1'b1};

  typedef struct {
    bit                        set_count;
    logic [dogc_pkg::VC_W-1:0] count_val;
    dogc_pkg::in_item_t        link;
    bit                        typed;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  dogc_pkg::in_item_t              in_item     = '0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  dogc_pkg::out_item_t             out_item;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [dogc_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [dogc_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [dogc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  degree_ordered_greedy_coloring u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow of the block: the adjacency matrix and the count register.
  logic [NV-1:0]             adj_rows [NV];
  logic [dogc_pkg::VC_W-1:0] vertex_limit = dogc_pkg::VC_RESET;
  dogc_pkg::out_item_t       pending_colours [$];

  // Flag travelling with the item on offer: its results are typed into the
  // plan rather than taken from the colouring predictor.
  bit typed_next = 1'b0;

  int send_gap_pct = 8;
  int recv_gap_pct = 64;
  bit hold_req     = 1'b0;
  int mismatches   = 0;
  int graphs_done  = 0;
  int links_taken  = 0;
  int colours_seen = 0;
  int count_writes = 0;
  int links_sent   = 0;
  int quiet        = 0;

  // A count of zero behaves as one vertex, anything above the matrix size as
  // the full matrix.
  function automatic int unsigned span_of(logic [dogc_pkg::VC_W-1:0] vc);
    if (vc == 0) return 1;
    if (vc > NV) return NV;
    return vc;
  endfunction

  // Records one edge item and, when it closes the graph, works out the full
  // colouring: rank by falling degree with lower index first, then give each
  // vertex the lowest colour none of its already coloured neighbours holds.
  task automatic absorb_link(input dogc_pkg::in_item_t it, input bit typed);
    int unsigned         n;
    int unsigned         v;
    int unsigned         c;
    logic [NV-1:0]       keep;
    logic [NV-1:0]       nbrs;
    logic [NV-1:0]       used;
    logic [NV-1:0]       painted;
    logic [3:0]          hue [NV];
    int unsigned         deg [NV];
    int unsigned         rank [$];
    dogc_pkg::out_item_t res;
    n    = span_of(vertex_limit);
    keep = (n >= NV) ? '1 : NV'((32'd1 << n) - 32'd1);
    if (it.end_a != it.end_b && it.end_a < n && it.end_b < n) begin
      adj_rows[it.end_a][it.end_b] = 1'b1;
      adj_rows[it.end_b][it.end_a] = 1'b1;
    end
    if (!it.final_edge) return;
    // Rows beyond the count are masked out here, which also covers a count
    // lowered after some of the edges went in.
    for (int i = 0; i < n; i++) deg[i] = $countones(adj_rows[i] & keep);
    for (int d = NV - 1; d >= 0; d--)
      for (int i = 0; i < n; i++)
        if (deg[i] == d) rank.insert(rank.size(), i);
    painted = '0;
    for (int k = 0; k < n; k++) begin
      v    = rank[k];
      nbrs = adj_rows[v] & keep;
      used = '0;
      for (int j = 0; j < n; j++)
        if (nbrs[j] && painted[j]) used[hue[j]] = 1'b1;
      c = 0;
      while (c < NV - 1 && used[c]) c++;
      hue[v]     = c[3:0];
      painted[v] = 1'b1;
      if (!typed) begin
        res = '{vertex_id: v[3:0], color_id: c[3:0], last_vertex: (k == n - 1)};
        pending_colours.insert(pending_colours.size(), res);
      end
    end
    if (typed) pending_colours.insert(pending_colours.size(), ONE_VERTEX);
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
    graphs_done++;
  endtask

  // Offers one edge item, with random idle cycles in front of it, and returns
  // at the clock edge at which the block takes it.
  task automatic send_link(input logic [3:0] a, input logic [3:0] b, input logic fin,
                           input bit typed);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_item    <= '{end_a: a, end_b: b, final_edge: fin};
    typed_next <= typed;
    do @(posedge clk); while (!in_ready);
    links_sent++;
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input logic [dogc_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [dogc_pkg::CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {dogc_pkg::REG_VERTEX_COUNT, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // The count may only change with no colouring in flight: stop offering
  // items, let the item just taken reach the predictor, let every expected
  // result drain, give the last edge time to land, then write and read back.
  task automatic set_count(input logic [dogc_pkg::VC_W-1:0] value);
    logic [dogc_pkg::CFG_DATA_W-1:0] rd;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_access(1'b1, dogc_pkg::CFG_DATA_W'(value), rd);
    vertex_limit = value;
    cfg_access(1'b0, '0, rd);
    if (rd[dogc_pkg::VC_W-1:0] !== value) begin
      $display("%0t: vertex_count read back, expected %0d, got %0d", $time, value,
               rd[dogc_pkg::VC_W-1:0]);
      mismatches++;
    end
    count_writes++;
  endtask

  function automatic plan_row_t link_row(logic [3:0] a, logic [3:0] b, logic fin,
                                         bit typed);
    return '{set_count: 1'b0, count_val: '0,
             link: '{end_a: a, end_b: b, final_edge: fin}, typed: typed};
  endfunction

  function automatic plan_row_t count_row(logic [dogc_pkg::VC_W-1:0] value);
    return '{set_count: 1'b1, count_val: value, link: '0, typed: 1'b0};
  endfunction

  // Often the extremes and the clamped values, otherwise anything in range.
  function automatic logic [dogc_pkg::VC_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 10) return dogc_pkg::VC_W'(0);
    if (r < 20) return dogc_pkg::VC_W'(1);
    if (r < 35) return dogc_pkg::VC_W'(NV);
    if (r < 45) return dogc_pkg::VC_W'($urandom_range(NV + 1, 31));
    return dogc_pkg::VC_W'($urandom_range(2, NV - 1));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so that the
  // block fills up and has to push back on its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Both handshakes are sampled here, at the edge, before anything driven at
  // that same edge takes effect.
  always @(posedge clk) begin : watch_ports
    dogc_pkg::out_item_t want;
    dogc_pkg::out_item_t got;
    if (rst_n && in_valid && in_ready) begin
      absorb_link(in_item, typed_next);
      links_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_item;
      colours_seen++;
      if (pending_colours.size() == 0) begin
        $display("%0t: colour result with none expected, got vertex %0d colour %0d last %0d",
                 $time, got.vertex_id, got.color_id, got.last_vertex);
        mismatches++;
      end else begin
        want = pending_colours.pop_front();
        if (got.vertex_id !== want.vertex_id || got.color_id !== want.color_id ||
            got.last_vertex !== want.last_vertex) begin
          $display("%0t: expected vertex %0d colour %0d last %0d, got vertex %0d colour %0d last %0d",
                   $time, want.vertex_id, want.color_id, want.last_vertex,
                   got.vertex_id, got.color_id, got.last_vertex);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any stretch this long with no handshake on any port means the
  // block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("degree_ordered_greedy_coloring: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    plan_row_t                       plan [$];
    logic [dogc_pkg::CFG_DATA_W-1:0] rd;
    int unsigned                     n;
    int unsigned                     k;
    int unsigned                     e;
    int                              stage;
    int                              next_stage;
    int                              shape;
    int                              goal;
    int                              calm;
    logic [3:0]                      a;
    logic [3:0]                      b;

    for (int i = 0; i < NV; i++) adj_rows[i] = '0;

    // Directed plan. After reset the count is the full matrix: a few edges,
    // a self-loop and a repeat, closed by a final edge.
    plan.insert(plan.size(), link_row(4'd0,  4'd15, 1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd15, 4'd15, 1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd15, 4'd0,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd5,  4'd3,  1'b1, 1'b0));
    // A count of zero acts as one vertex; the edge falls outside it.
    plan.insert(plan.size(), count_row(5'd0));
    plan.insert(plan.size(), link_row(4'd0,  4'd1,  1'b1, 1'b1));
    // The largest register value is clamped to the matrix size; a star and
    // a triangle share vertices so the ranking and colours both matter.
    plan.insert(plan.size(), count_row(5'd31));
    plan.insert(plan.size(), link_row(4'd7,  4'd1,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd7,  4'd2,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd7,  4'd3,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd1,  4'd2,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd2,  4'd3,  1'b1, 1'b0));
    // Four vertices: an edge to vertex four is out of range and dropped.
    plan.insert(plan.size(), count_row(5'd4));
    plan.insert(plan.size(), link_row(4'd3,  4'd4,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd0,  4'd1,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd1,  4'd2,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd2,  4'd0,  1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd3,  4'd0,  1'b1, 1'b0));
    // Count lowered between edges: the high rows must be ignored, then cleared.
    plan.insert(plan.size(), count_row(5'd16));
    plan.insert(plan.size(), link_row(4'd10, 4'd12, 1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd12, 4'd14, 1'b0, 1'b0));
    plan.insert(plan.size(), link_row(4'd1,  4'd2,  1'b0, 1'b0));
    plan.insert(plan.size(), count_row(5'd3));
    plan.insert(plan.size(), link_row(4'd0,  4'd2,  1'b1, 1'b0));
    plan.insert(plan.size(), count_row(5'd1));
    plan.insert(plan.size(), link_row(4'd15, 4'd15, 1'b1, 1'b1));
    plan.insert(plan.size(), count_row(5'd2));
    plan.insert(plan.size(), link_row(4'd1,  4'd0,  1'b1, 1'b0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The register must come out of reset at the full matrix size.
    cfg_access(1'b0, '0, rd);
    if (rd[dogc_pkg::VC_W-1:0] !== dogc_pkg::VC_RESET) begin
      $display("%0t: vertex_count after reset, expected %0d, got %0d", $time,
               dogc_pkg::VC_RESET, rd[dogc_pkg::VC_W-1:0]);
      mismatches++;
    end

    foreach (plan[i]) begin
      if (plan[i].set_count) set_count(plan[i].count_val);
      else send_link(plan[i].link.end_a, plan[i].link.end_b, plan[i].link.final_edge,
                     plan[i].typed);
    end

    // Random graphs in three stretches: sender idling lightly and receiver
    // heavily, then the reverse, then neither. The last stretch opens with a
    // long receiver hold-off on a full-size graph, followed straight away by
    // more items so that the input has to stall.
    stage = 0;
    calm  = 0;
    goal  = links_sent + RANDOM_ITEMS;
    while (links_sent < goal) begin
      next_stage = (RANDOM_ITEMS - (goal - links_sent)) * 3 / RANDOM_ITEMS;
      if (next_stage > 2) next_stage = 2;
      if (next_stage != stage) begin
        stage = next_stage;
        if (stage == 1) begin
          send_gap_pct = 64;
          recv_gap_pct = 8;
        end else begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
          set_count(5'd16);
          hold_req = 1'b1;
          calm     = 2;
        end
      end else if (calm == 0 && $urandom_range(99) < 50) begin
        set_count(pick_count());
      end
      n     = span_of(vertex_limit);
      shape = (calm == 2) ? 50 : $urandom_range(99);
      if (calm != 0) calm--;
      if (shape < 15) begin
        // Complete graph on a few low vertices: pushes the colours upwards.
        k = (n < 7) ? n : $urandom_range(2, 7);
        if (k < 2) begin
          send_link(4'd0, 4'd0, 1'b1, 1'b0);
        end else begin
          for (int i = 0; i < k; i++)
            for (int j = i + 1; j < k; j++) begin
              a = i[3:0];
              b = j[3:0];
              if ($urandom_range(1)) send_link(b, a, (i == k - 2), 1'b0);
              else send_link(a, b, (i == k - 2), 1'b0);
            end
        end
      end else if (shape < 85) begin
        // Well-formed graph: ends mostly within the count, closed by a final edge.
        e = $urandom_range(1, 12);
        for (int i = 0; i < e; i++) begin
          if ($urandom_range(9) != 0) begin
            a = 4'($urandom_range(n - 1));
            b = 4'($urandom_range(n - 1));
          end else begin
            a = 4'($urandom_range(15));
            b = 4'($urandom_range(15));
          end
          send_link(a, b, (i == e - 1), 1'b0);
        end
      end else begin
        // Noise: any ends, and the final mark may or may not come.
        e = $urandom_range(1, 6);
        for (int i = 0; i < e; i++)
          send_link(4'($urandom_range(15)), 4'($urandom_range(15)),
                    ($urandom_range(4) == 0), 1'b0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (RUN_CYCLES) @(posedge clk);
    if (pending_colours.size() != 0) begin
      $display("%0t: %0d colour results never arrived", $time, pending_colours.size());
      mismatches++;
    end

    $display("Coloured %0d graphs from %0d edge items, %0d results checked,",
             graphs_done, links_taken, colours_seen);
    $display("with %0d vertex_count writes and idling on each side in turn.", count_writes);
    if (mismatches == 0) begin
      $display("degree_ordered_greedy_coloring: match");
    end else begin
      $display("degree_ordered_greedy_coloring: mismatch");
    end
    $finish;
  end

endmodule

### degree_ordered_greedy_coloring.f
hw/rtl/dogc_pkg.sv
hw/rtl/dogc_dp.sv
hw/rtl/dogc_ctrl.sv
hw/rtl/degree_ordered_greedy_coloring.sv
tb/degree_ordered_greedy_coloring_test.sv
